// ----- src/open_loop_speed_ramp_angle_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the open-loop speed ramp angle generator
// Clocked concurrent assertion helpers; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef OPEN_LOOP_SPEED_RAMP_ANGLE_TOP_DEFINES_SVH
`define OPEN_LOOP_SPEED_RAMP_ANGLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked property, disabled while reset is asserted
`define OLSRA_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("olsra assertion failed");
// clocked property, checked during reset as well
`define OLSRA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("olsra assertion failed");
`else
`define OLSRA_ASSERT_CLK(lbl, clk, rst_n, prop)
`define OLSRA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- src/olsra_pkg.sv -----
// ----------------------------------------------------------------------------
// olsra_pkg
// Shared types and constants of the open-loop speed ramp angle generator.
// ----------------------------------------------------------------------------
`default_nettype none

package olsra_pkg;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic [1:0] ACT_STEP         = 2'd0;
  localparam logic [1:0] ACT_PRESET_SPEED = 2'd1;
  localparam logic [1:0] ACT_PRESET_ANGLE = 2'd2;
  localparam logic [1:0] ACT_RESET        = 2'd3;

  localparam logic CFG_TARGET_SPEED = 1'b0;
  localparam logic CFG_ACCELERATION = 1'b1;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_BAD_PERIOD  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DELTA,
    ST_SLEW,
    ST_MUL_ANGLE,
    ST_ANGLE,
    ST_WB
  } olsra_state_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } olsra_mul_req_t;

endpackage

`default_nettype wire

// ----- src/open_loop_speed_ramp_angle_top.sv -----
// ----------------------------------------------------------------------------
// open_loop_speed_ramp_angle_top
// Step: passes ST_MUL_DELTA, ST_SLEW, ST_MUL_ANGLE, ST_ANGLE and ST_WB; the
// multiplier is shared by the slew delta and the angle increment.
// Preset, reset and invalid-period steps go straight from ST_IDLE to ST_WB.
// New inputs are stalled outside ST_IDLE; ST_WB holds while out is stalled.
// Synchronous active-low reset clears speed, angle, config and valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "open_loop_speed_ramp_angle_top_defines.svh"

module open_loop_speed_ramp_angle_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_wdata,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [31:0] in_sample_period,
  input  wire logic [31:0]        in_timestamp,
  input  wire logic signed [31:0] in_load_value,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_electrical_angle,
  output logic signed [31:0]      out_electrical_speed,
  output logic [31:0]             out_stamp_out,
  output logic                    out_status
);

  olsra_pkg::olsra_state_t state_r, state_nxt;

  logic signed [31:0] target_r, accel_r;
  logic signed [31:0] speed_r, speed_nxt;
  logic [31:0]        angle_r, angle_nxt;
  logic signed [31:0] period_r;
  logic [31:0]        stamp_r;
  logic               status_r, status_nxt;
  logic               out_valid_r;

  logic               in_xfer;
  logic               out_free;
  logic               bad_period;
  logic signed [31:0] accel_mag;
  logic signed [31:0] mul_res;
  logic signed [32:0] sum_up, sum_dn, tgt_ext;
  olsra_pkg::olsra_mul_req_t mul_req;

  assign in_stall   = (state_r != olsra_pkg::ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign bad_period = in_sample_period[31] || (in_sample_period == 32'sd0);
  assign accel_mag  = !accel_r[31] ? accel_r :
                      (accel_r == olsra_pkg::S32_MIN) ? olsra_pkg::S32_MAX : -accel_r;
  assign tgt_ext    = 33'(target_r);
  assign sum_up     = 33'(speed_r) + 33'(mul_res);
  assign sum_dn     = 33'(speed_r) - 33'(mul_res);

  olsra_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olsra_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_action == olsra_pkg::ACT_STEP && !bad_period) begin
            state_nxt = olsra_pkg::ST_MUL_DELTA;
          end else begin
            state_nxt = olsra_pkg::ST_WB;
          end
        end
      end
      olsra_pkg::ST_MUL_DELTA: state_nxt = olsra_pkg::ST_SLEW;
      olsra_pkg::ST_SLEW:      state_nxt = olsra_pkg::ST_MUL_ANGLE;
      olsra_pkg::ST_MUL_ANGLE: state_nxt = olsra_pkg::ST_ANGLE;
      olsra_pkg::ST_ANGLE:     state_nxt = olsra_pkg::ST_WB;
      olsra_pkg::ST_WB: begin
        if (out_free) begin
          state_nxt = olsra_pkg::ST_IDLE;
        end
      end
      default: state_nxt = olsra_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    speed_nxt   = speed_r;
    angle_nxt   = angle_r;
    status_nxt  = status_r;
    mul_req.en  = 1'b0;
    mul_req.a   = accel_mag;
    mul_req.b   = period_r;
    case (state_r)
      olsra_pkg::ST_IDLE: begin
        if (in_xfer) begin
          status_nxt = olsra_pkg::STATUS_OK;
          case (in_action)
            olsra_pkg::ACT_STEP: begin
              if (bad_period) begin
                status_nxt = olsra_pkg::STATUS_BAD_PERIOD;
              end
            end
            olsra_pkg::ACT_PRESET_SPEED: speed_nxt = in_load_value;
            olsra_pkg::ACT_PRESET_ANGLE: angle_nxt = in_load_value;
            olsra_pkg::ACT_RESET: begin
              speed_nxt = 32'sd0;
              angle_nxt = 32'd0;
            end
            default: begin
              speed_nxt = speed_r;
            end
          endcase
        end
      end
      olsra_pkg::ST_MUL_DELTA: begin
        mul_req.en = 1'b1;
      end
      olsra_pkg::ST_SLEW: begin
        if (speed_r < target_r) begin
          speed_nxt = (sum_up > tgt_ext) ? target_r : sum_up[31:0];
        end else if (speed_r > target_r) begin
          speed_nxt = (sum_dn < tgt_ext) ? target_r : sum_dn[31:0];
        end
      end
      olsra_pkg::ST_MUL_ANGLE: begin
        mul_req.en = 1'b1;
        mul_req.a  = speed_r;
      end
      olsra_pkg::ST_ANGLE: begin
        angle_nxt = angle_r + 32'(mul_res << (32 - FRAC_BITS));
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olsra_pkg::ST_IDLE;
      target_r    <= 32'sd0;
      accel_r     <= 32'sd0;
      speed_r     <= 32'sd0;
      angle_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      speed_r <= speed_nxt;
      angle_r <= angle_nxt;
      if (cfg_we) begin
        case (cfg_index)
          olsra_pkg::CFG_TARGET_SPEED: target_r <= cfg_wdata;
          olsra_pkg::CFG_ACCELERATION: accel_r  <= cfg_wdata;
          default: target_r <= target_r;
        endcase
      end
      if (state_r == olsra_pkg::ST_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (in_xfer) begin
      period_r <= in_sample_period;
      stamp_r  <= in_timestamp;
    end
    if (state_r == olsra_pkg::ST_WB && out_free) begin
      out_electrical_angle <= angle_r;
      out_electrical_speed <= speed_r;
      out_stamp_out        <= stamp_r;
      out_status           <= status_r;
    end
  end

  assign out_valid = out_valid_r;

  `OLSRA_ASSERT_CLK(a_xfer_busy, clk, rst_n, in_xfer |=> (state_r != olsra_pkg::ST_IDLE))
  `OLSRA_ASSERT_CLK(a_angle_to_wb, clk, rst_n,
    (state_r == olsra_pkg::ST_ANGLE) |=> (state_r == olsra_pkg::ST_WB))
  `OLSRA_ASSERT_CLK(a_wb_shows, clk, rst_n,
    (state_r == olsra_pkg::ST_WB && out_free) |=> out_valid_r)
  `OLSRA_ASSERT_CLK(a_result_held, clk, rst_n,
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_electrical_angle)))

endmodule

`default_nettype wire

// ----- src/olsra_mul.sv -----
// ----------------------------------------------------------------------------
// olsra_mul
// Shared fixed-point multiplier: registered 32x32 signed product, then a
// floor shift by FRAC_BITS and saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module olsra_mul #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire olsra_pkg::olsra_mul_req_t req,
  output logic signed [31:0]            res
);

  logic signed [63:0]     prod_r;
  logic signed [31:0]     shifted;
  logic [32-FRAC_BITS:0]  hi;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= 64'(req.a) * 64'(req.b);
    end
  end

  assign shifted = prod_r[31+FRAC_BITS:FRAC_BITS];
  assign hi      = prod_r[63:31+FRAC_BITS];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      res = shifted;
    end else if (prod_r[63]) begin
      res = olsra_pkg::S32_MIN;
    end else begin
      res = olsra_pkg::S32_MAX;
    end
  end

endmodule

`default_nettype wire
